[hw/rtl/bale_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bale_pkg
// shared request, status codes and widths for the array list engine
// ----------------------------------------------------------------------------
package bale_pkg;

  localparam int unsigned MAX_ENTRIES = 64;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned POS_W       = 6;
  localparam int unsigned CNT_W       = 7;

  typedef enum logic [2:0] {
    REQ_PUSH   = 3'd0,
    REQ_POP    = 3'd1,
    REQ_INSERT = 3'd2,
    REQ_ERASE  = 3'd3,
    REQ_FIND   = 3'd4,
    REQ_READ   = 3'd5,
    REQ_SORT   = 3'd6,
    REQ_NOP    = 3'd7
  } req_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_RANGE    = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  // one finished result
  typedef struct packed {
    logic [2:0]        status;
    logic [WORD_W-1:0] data;
    logic [POS_W-1:0]  found_index;
    logic [CNT_W-1:0]  count;
  } result_t;

endpackage

[hw/rtl/bounded_array_list_engine_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_array_list_engine_top
// ordered list of signed words with push, pop, insert, erase, find, read, sort
// ----------------------------------------------------------------------------
// One request is worked at a time against an entry memory with one write
// port and one registered read port. Push, append, erase of the last entry,
// rejected requests and the unused code finish straight from idle; pop and
// read wait for the memory read; insert moves the entries from the tail down
// to position p one place up, then writes the value; erase moves the entries
// after p one place down; find walks from entry 0 to the first match or the
// end; sort is a stable insertion sort in signed order. A finished result
// leaves the sequencer for the output register, so the next request is taken
// while a result waits; the input stalls while the sequencer is busy or still
// holds a finished result.
module bounded_array_list_engine_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_req_type,
  input  logic [31:0] in_value,
  input  logic [5:0]  in_position,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [31:0] out_data,
  output logic [5:0]  out_found_index,
  output logic [6:0]  out_count,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int unsigned AW = bale_pkg::POS_W;
  localparam int unsigned CW = bale_pkg::CNT_W;

  // capacity register, reset to 64
  logic [6:0] cap_r;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = {25'd0, cap_r};
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= 7'd64;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 2'd0) begin
      cap_r <= cfg_pwdata[6:0];
    end
  end

  // capacity clamped to the store size
  logic [CW-1:0] cap_eff;
  assign cap_eff = (cap_r > CW'(bale_pkg::MAX_ENTRIES)) ? CW'(bale_pkg::MAX_ENTRIES) : cap_r;

  logic busy, done;
  bale_pkg::result_t res;
  bale_pkg::result_t out_res_r;
  logic out_valid_r;
  logic res_pend_r;   // finished result still in the sequencer
  logic have_res;
  logic load_out;

  // a result is ready in the sequencer this cycle or held from before
  assign have_res = done || res_pend_r;
  // move it out when the output register is free or draining
  assign load_out = have_res && (!out_valid_r || out_ready);

  // accept only with the sequencer idle and its result moved out
  assign in_ready  = !busy && !have_res;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      res_pend_r  <= 1'b0;
      out_res_r   <= '0;
    end else begin
      res_pend_r <= have_res && !load_out;
      if (load_out) begin
        out_valid_r <= 1'b1;
        out_res_r   <= res;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_status      = out_res_r.status;
  assign out_data        = out_res_r.data;
  assign out_found_index = out_res_r.found_index;
  assign out_count       = out_res_r.count;

  logic mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [31:0] mem_wdata, mem_rdata;

  bale_ctrl u_ctrl (
    .clk, .rst_n,
    .start(in_valid && in_ready),
    .req_type(in_req_type), .value(in_value), .position(in_position),
    .cap(cap_eff), .busy, .done, .result(res),
    .mem_we, .mem_waddr, .mem_wdata, .mem_raddr, .mem_rdata
  );

  bale_mem #(.DEPTH(bale_pkg::MAX_ENTRIES), .AW(AW)) u_mem (
    .clk, .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

endmodule

[hw/rtl/bale_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bale_mem
// entry store, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module bale_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [bale_pkg::WORD_W-1:0] wdata,
  input  logic [AW-1:0]              raddr,
  output logic [bale_pkg::WORD_W-1:0] rdata
);

  logic [bale_pkg::WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/bale_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bale_ctrl
// request sequencer: walks the store for shifts, find and sort
// ----------------------------------------------------------------------------
module bale_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [2:0]                  req_type,
  input  logic [bale_pkg::WORD_W-1:0] value,
  input  logic [bale_pkg::POS_W-1:0]  position,
  input  logic [bale_pkg::CNT_W-1:0]  cap,
  output logic                        busy,
  output logic                        done,
  output bale_pkg::result_t           result,
  output logic                        mem_we,
  output logic [bale_pkg::POS_W-1:0]  mem_waddr,
  output logic [bale_pkg::WORD_W-1:0] mem_wdata,
  output logic [bale_pkg::POS_W-1:0]  mem_raddr,
  input  logic [bale_pkg::WORD_W-1:0] mem_rdata
);

  localparam int unsigned AW = bale_pkg::POS_W;
  localparam int unsigned CW = bale_pkg::CNT_W;

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_SHUP, S_PLACE, S_SHDN, S_FIND, S_SORT_LD, S_SORT_CMP, S_SORT_PUT
  } state_t;

  state_t                      state_r, state_nxt;
  logic [CW-1:0]               count_r, count_nxt;
  logic [CW-1:0]               idx_r, idx_nxt;       // walking index
  logic [CW-1:0]               lim_r, lim_nxt;       // requested position
  logic [CW-1:0]               sort_i_r, sort_i_nxt; // outer sort index
  logic [bale_pkg::WORD_W-1:0] held_r, held_nxt;
  logic [bale_pkg::WORD_W-1:0] val_r, val_nxt;
  bale_pkg::result_t           result_r, result_nxt;
  logic                        done_r, done_nxt;

  logic [CW-1:0] pos_x;
  logic          full_c;
  logic [AW-1:0] last_a;

  assign pos_x  = CW'(position);
  assign full_c = (count_r >= cap);
  assign last_a = AW'(count_r - CW'(1));

  assign busy   = (state_r != S_IDLE);
  assign done   = done_r;
  assign result = result_r;

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    lim_nxt    = lim_r;
    sort_i_nxt = sort_i_r;
    held_nxt   = held_r;
    val_nxt    = val_r;
    result_nxt = result_r;
    done_nxt   = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = idx_r[AW-1:0];
    mem_wdata  = mem_rdata;
    mem_raddr  = idx_r[AW-1:0];
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          val_nxt          = value;
          lim_nxt          = pos_x;
          result_nxt       = '0;
          result_nxt.count = count_r;
          unique case (bale_pkg::req_t'(req_type))
            bale_pkg::REQ_PUSH: begin
              done_nxt = 1'b1;
              if (full_c) begin
                result_nxt.status = bale_pkg::ST_FULL;
              end else begin
                mem_we           = 1'b1;
                mem_waddr        = count_r[AW-1:0];
                mem_wdata        = value;
                count_nxt        = count_r + CW'(1);
                result_nxt.count = count_r + CW'(1);
              end
            end
            bale_pkg::REQ_POP: begin
              if (count_r == '0) begin
                done_nxt          = 1'b1;
                result_nxt.status = bale_pkg::ST_EMPTY;
              end else begin
                mem_raddr        = last_a;
                count_nxt        = count_r - CW'(1);
                result_nxt.count = count_r - CW'(1);
                state_nxt        = S_READ;
              end
            end
            bale_pkg::REQ_INSERT: begin
              if (full_c) begin
                done_nxt          = 1'b1;
                result_nxt.status = bale_pkg::ST_FULL;
              end else if (pos_x > count_r) begin
                done_nxt          = 1'b1;
                result_nxt.status = bale_pkg::ST_RANGE;
              end else if (pos_x == count_r) begin
                // append, nothing to move
                done_nxt         = 1'b1;
                mem_we           = 1'b1;
                mem_waddr        = position;
                mem_wdata        = value;
                count_nxt        = count_r + CW'(1);
                result_nxt.count = count_r + CW'(1);
              end else begin
                // read the tail now, move upward walking down to the position
                mem_raddr = last_a;
                idx_nxt   = count_r;
                state_nxt = S_SHUP;
              end
            end
            bale_pkg::REQ_ERASE: begin
              if (pos_x >= count_r) begin
                done_nxt          = 1'b1;
                result_nxt.status = bale_pkg::ST_RANGE;
              end else if (pos_x + CW'(1) == count_r) begin
                done_nxt         = 1'b1;
                count_nxt        = count_r - CW'(1);
                result_nxt.count = count_r - CW'(1);
              end else begin
                mem_raddr = AW'(pos_x + CW'(1));
                idx_nxt   = pos_x;
                state_nxt = S_SHDN;
              end
            end
            bale_pkg::REQ_FIND: begin
              if (count_r == '0) begin
                done_nxt          = 1'b1;
                result_nxt.status = bale_pkg::ST_NOTFOUND;
              end else begin
                mem_raddr = '0;
                idx_nxt   = '0;
                state_nxt = S_FIND;
              end
            end
            bale_pkg::REQ_READ: begin
              if (pos_x >= count_r) begin
                done_nxt          = 1'b1;
                result_nxt.status = bale_pkg::ST_RANGE;
              end else begin
                mem_raddr = position;
                state_nxt = S_READ;
              end
            end
            bale_pkg::REQ_SORT: begin
              if (count_r < CW'(2)) begin
                done_nxt = 1'b1;
              end else begin
                mem_raddr  = AW'(1);
                sort_i_nxt = CW'(1);
                idx_nxt    = CW'(1);
                state_nxt  = S_SORT_LD;
              end
            end
            bale_pkg::REQ_NOP: done_nxt = 1'b1;
          endcase
        end
      end
      S_READ: begin
        result_nxt.data = mem_rdata;
        done_nxt        = 1'b1;
        state_nxt       = S_IDLE;
      end
      S_SHUP: begin
        // entry idx-1 arrives and moves to idx
        mem_we    = 1'b1;
        mem_waddr = idx_r[AW-1:0];
        mem_wdata = mem_rdata;
        mem_raddr = AW'(idx_r - CW'(2));
        idx_nxt   = idx_r - CW'(1);
        if (idx_r == lim_r + CW'(1)) begin
          state_nxt = S_PLACE;
        end
      end
      S_PLACE: begin
        mem_we           = 1'b1;
        mem_waddr        = lim_r[AW-1:0];
        mem_wdata        = val_r;
        count_nxt        = count_r + CW'(1);
        result_nxt.count = count_r + CW'(1);
        done_nxt         = 1'b1;
        state_nxt        = S_IDLE;
      end
      S_SHDN: begin
        // entry idx+1 arrives and moves to idx
        mem_we    = 1'b1;
        mem_waddr = idx_r[AW-1:0];
        mem_wdata = mem_rdata;
        mem_raddr = AW'(idx_r + CW'(2));
        idx_nxt   = idx_r + CW'(1);
        if (idx_r + CW'(2) == count_r) begin
          count_nxt        = count_r - CW'(1);
          result_nxt.count = count_r - CW'(1);
          done_nxt         = 1'b1;
          state_nxt        = S_IDLE;
        end
      end
      S_FIND: begin
        mem_raddr = AW'(idx_r + CW'(1));
        idx_nxt   = idx_r + CW'(1);
        if (mem_rdata == val_r) begin
          result_nxt.found_index = idx_r[AW-1:0];
          done_nxt               = 1'b1;
          state_nxt              = S_IDLE;
        end else if (idx_r + CW'(1) == count_r) begin
          result_nxt.status = bale_pkg::ST_NOTFOUND;
          done_nxt          = 1'b1;
          state_nxt         = S_IDLE;
        end
      end
      S_SORT_LD: begin
        held_nxt  = mem_rdata;
        mem_raddr = AW'(idx_r - CW'(1));
        state_nxt = S_SORT_CMP;
      end
      S_SORT_CMP: begin
        // rdata holds entry idx-1 while held belongs at or below slot idx
        mem_we    = 1'b1;
        mem_waddr = idx_r[AW-1:0];
        if ($signed(mem_rdata) > $signed(held_r)) begin
          mem_wdata = mem_rdata;
          mem_raddr = AW'(idx_r - CW'(2));
          idx_nxt   = idx_r - CW'(1);
          if (idx_r == CW'(1)) begin
            state_nxt = S_SORT_PUT;
          end
        end else begin
          mem_wdata = held_r;
          mem_raddr = AW'(sort_i_r + CW'(1));
          if (sort_i_r + CW'(1) == count_r) begin
            done_nxt  = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            sort_i_nxt = sort_i_r + CW'(1);
            idx_nxt    = sort_i_r + CW'(1);
            state_nxt  = S_SORT_LD;
          end
        end
      end
      S_SORT_PUT: begin
        // held belongs at slot 0
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = held_r;
        mem_raddr = AW'(sort_i_r + CW'(1));
        if (sort_i_r + CW'(1) == count_r) begin
          done_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          sort_i_nxt = sort_i_r + CW'(1);
          idx_nxt    = sort_i_r + CW'(1);
          state_nxt  = S_SORT_LD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      idx_r    <= '0;
      lim_r    <= '0;
      sort_i_r <= '0;
      held_r   <= '0;
      val_r    <= '0;
      result_r <= '0;
      done_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      idx_r    <= idx_nxt;
      lim_r    <= lim_nxt;
      sort_i_r <= sort_i_nxt;
      held_r   <= held_nxt;
      val_r    <= val_nxt;
      result_r <= result_nxt;
      done_r   <= done_nxt;
    end
  end

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks the array list engine against a built-in list predictor
// ----------------------------------------------------------------------------
// Requests are queued by an initial block and sent by a clocked driver; a
// clocked monitor compares every result with the oldest prediction. The list
// predictor keeps its own copy of the entries, count and capacity. Phases
// run at several capacity settings, each one written over the APB port
// while the engine is idle.
module testbench;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned POS_HINT = 24;

  typedef struct packed {
    bale_pkg::req_t kind;
    logic [31:0]    value;
    logic [5:0]     position;
  } list_req_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_req_type;
  logic [31:0] in_value;
  logic [5:0]  in_position;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_status;
  logic [31:0] out_data;
  logic [5:0]  out_found_index;
  logic [6:0]  out_count;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [1:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  bounded_array_list_engine_top u_top (.*);

  // predictor state
  logic [31:0] pred_entries [DEPTH];
  int unsigned pred_count = 0;
  int unsigned pred_capacity = 64;

  list_req_t         pending_reqs[$];
  bale_pkg::result_t expected_results[$];

  int  mismatches = 0;
  int  idle_cycles = 0;
  bit  calm;          // no idling near the end
  int  send_gap;
  int  sink_gap;
  logic in_taken;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // list predictor: one result per request
  function automatic bale_pkg::result_t predict_list(list_req_t r);
    bale_pkg::result_t res;
    int unsigned cap;
    int unsigned i;
    int unsigned j;
    logic [31:0] held;
    res = '0;
    res.status = bale_pkg::ST_OK;
    cap = (pred_capacity > DEPTH) ? DEPTH : pred_capacity;
    case (r.kind)
      bale_pkg::REQ_PUSH: begin
        if (pred_count >= cap) res.status = bale_pkg::ST_FULL;
        else begin
          pred_entries[pred_count] = r.value;
          pred_count++;
        end
      end
      bale_pkg::REQ_POP: begin
        if (pred_count == 0) res.status = bale_pkg::ST_EMPTY;
        else begin
          pred_count--;
          res.data = pred_entries[pred_count];
        end
      end
      bale_pkg::REQ_INSERT: begin
        if (pred_count >= cap) res.status = bale_pkg::ST_FULL;
        else if (r.position > pred_count) res.status = bale_pkg::ST_RANGE;
        else begin
          for (i = pred_count; i > r.position; i--) pred_entries[i] = pred_entries[i-1];
          pred_entries[r.position] = r.value;
          pred_count++;
        end
      end
      bale_pkg::REQ_ERASE: begin
        if (r.position >= pred_count) res.status = bale_pkg::ST_RANGE;
        else begin
          for (i = r.position; i + 1 < pred_count; i++) pred_entries[i] = pred_entries[i+1];
          pred_count--;
        end
      end
      bale_pkg::REQ_FIND: begin
        res.status = bale_pkg::ST_NOTFOUND;
        for (i = 0; i < pred_count; i++) begin
          if (pred_entries[i] == r.value) begin
            res.status = bale_pkg::ST_OK;
            res.found_index = i[5:0];
            break;
          end
        end
      end
      bale_pkg::REQ_READ: begin
        if (r.position >= pred_count) res.status = bale_pkg::ST_RANGE;
        else res.data = pred_entries[r.position];
      end
      bale_pkg::REQ_SORT: begin
        // stable insertion sort in signed order
        for (i = 1; i < pred_count; i++) begin
          held = pred_entries[i];
          j = i;
          while (j > 0 && $signed(pred_entries[j-1]) > $signed(held)) begin
            pred_entries[j] = pred_entries[j-1];
            j--;
          end
          pred_entries[j] = held;
        end
      end
      default: ;
    endcase
    res.count = pred_count[6:0];
    return res;
  endfunction

  // acceptance as seen at the last rising edge
  always @(posedge clk) begin
    if (!rst_n) in_taken <= 1'b0;
    else in_taken <= in_valid && in_ready;
  end

  // driver: inputs change on the falling edge
  always @(negedge clk) begin
    list_req_t next_req;
    if (!rst_n) begin
      in_valid    <= 1'b0;
      in_req_type <= bale_pkg::REQ_NOP;
      in_value    <= '0;
      in_position <= '0;
      send_gap    <= 0;
    end else if (in_valid && !in_taken) begin
      // hold the request until taken
    end else if (send_gap > 0) begin
      in_valid <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (pending_reqs.size() > 0 && !calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      send_gap <= $urandom_range(0, 3);
    end else if (pending_reqs.size() > 0) begin
      next_req     = pending_reqs.pop_front();
      in_valid    <= 1'b1;
      in_req_type <= next_req.kind;
      in_value    <= next_req.value;
      in_position <= next_req.position;
      expected_results = {expected_results, predict_list(next_req)};
    end else begin
      in_valid <= 1'b0;
    end
  end

  // receiver stalls on the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      sink_gap  <= 0;
    end else if (sink_gap > 0) begin
      out_ready <= 1'b0;
      sink_gap  <= sink_gap - 1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      out_ready <= 1'b0;
      sink_gap  <= $urandom_range(0, 3);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // monitor and watchdog on the rising edge
  always @(posedge clk) begin
    bale_pkg::result_t want;
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected result status=%0d", out_status);
        end else begin
          want = expected_results.pop_front();
          if (out_status !== want.status || out_data !== want.data ||
              out_found_index !== want.found_index || out_count !== want.count) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("mismatch: exp st=%0d d=%h fi=%0d c=%0d got st=%0d d=%h fi=%0d c=%0d",
                       want.status, want.data, want.found_index, want.count,
                       out_status, out_data, out_found_index, out_count);
          end
        end
      end
    end
  end

  task automatic write_capacity(input logic [31:0] cap);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= 2'd0;
    cfg_pwdata  <= cap;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    pred_capacity = cap[6:0];
  endtask

  // waits until the engine has drained every request
  task automatic drain_list();
    while (pending_reqs.size() > 0 || expected_results.size() > 0 || in_valid)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic queue_req(input bale_pkg::req_t k, input logic [31:0] v,
                           input logic [5:0] p);
    list_req_t r;
    r.kind = k;
    r.value = v;
    r.position = p;
    pending_reqs = {pending_reqs, r};
  endtask

  // random request biased toward positions up to n+1 and small or extreme values
  task automatic queue_random(input int unsigned n);
    int unsigned    sel;
    logic [31:0]    v;
    logic [5:0]     p;
    bale_pkg::req_t k;
    sel = $urandom_range(0, 99);
    if (sel < 30) k = bale_pkg::REQ_PUSH;
    else if (sel < 42) k = bale_pkg::REQ_POP;
    else if (sel < 60) k = bale_pkg::REQ_INSERT;
    else if (sel < 72) k = bale_pkg::REQ_ERASE;
    else if (sel < 82) k = bale_pkg::REQ_FIND;
    else if (sel < 94) k = bale_pkg::REQ_READ;
    else if (sel < 98) k = bale_pkg::REQ_SORT;
    else k = bale_pkg::REQ_NOP;
    case ($urandom_range(0, 3))
      0: v = $urandom_range(0, 7) - 4;
      1: v = {$urandom_range(0, 1) ? 1'b1 : 1'b0, 31'h7fffffff};
      default: v = $urandom;
    endcase
    p = ($urandom_range(0, 4) == 0) ? 6'($urandom) : 6'($urandom_range(0, n + 1));
    queue_req(k, v, p);
  endtask

  initial begin
    int unsigned phase_caps [5] = '{64, 8, 127, 1, 20};
    int unsigned ph;
    rst_n = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    calm = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty-list edge cases, extremes, every request
    queue_req(bale_pkg::REQ_POP, 32'h0, 6'd0);
    queue_req(bale_pkg::REQ_ERASE, 32'h0, 6'd0);
    queue_req(bale_pkg::REQ_READ, 32'h0, 6'd0);
    queue_req(bale_pkg::REQ_FIND, 32'h0, 6'd0);
    queue_req(bale_pkg::REQ_SORT, 32'h0, 6'd0);
    queue_req(bale_pkg::REQ_PUSH, 32'h7fffffff, 6'd63);
    queue_req(bale_pkg::REQ_SORT, 32'h0, 6'd0);
    queue_req(bale_pkg::REQ_PUSH, 32'h80000000, 6'd0);
    queue_req(bale_pkg::REQ_INSERT, 32'hffffffff, 6'd0);
    queue_req(bale_pkg::REQ_INSERT, 32'h00000000, 6'd3);
    queue_req(bale_pkg::REQ_INSERT, 32'h5, 6'd63);
    queue_req(bale_pkg::REQ_PUSH, 32'hffffffff, 6'd0);
    queue_req(bale_pkg::REQ_FIND, 32'hffffffff, 6'd0);
    queue_req(bale_pkg::REQ_FIND, 32'h12345678, 6'd0);
    queue_req(bale_pkg::REQ_SORT, 32'h0, 6'd0);
    queue_req(bale_pkg::REQ_READ, 32'h0, 6'd4);
    queue_req(bale_pkg::REQ_READ, 32'h0, 6'd5);
    queue_req(bale_pkg::REQ_ERASE, 32'h0, 6'd63);
    queue_req(bale_pkg::REQ_ERASE, 32'h0, 6'd1);
    queue_req(bale_pkg::REQ_NOP, 32'hffffffff, 6'd63);
    queue_req(bale_pkg::REQ_POP, 32'h0, 6'd0);
    drain_list();

    // capacity zero: everything that grows reports full
    write_capacity(0);
    queue_req(bale_pkg::REQ_PUSH, 32'h1, 6'd0);
    queue_req(bale_pkg::REQ_INSERT, 32'h1, 6'd40);
    drain_list();

    for (ph = 0; ph < 5; ph++) begin
      write_capacity(phase_caps[ph]);
      if (ph == 4) calm = 1'b1;
      for (int i = 0; i < 120; i++) begin
        // fill hard at the start of the first phase so the full limit is reached
        if (ph == 0 && i < 70) queue_req(bale_pkg::REQ_PUSH, $urandom, 6'($urandom));
        else queue_random(POS_HINT);
      end
      drain_list();
    end
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/bale_pkg.sv
hw/rtl/bale_mem.sv
hw/rtl/bale_ctrl.sv
hw/rtl/bounded_array_list_engine_top.sv
test/testbench.sv
